### hw/rtl/sln_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sln_pkg: shared constants and types
// Sizes, status codes and opcodes for the nearest-key skip list block.
// ----------------------------------------------------------------------------
package sln_pkg;
   localparam int NODES      = 1024;
   localparam int LEVELS     = 16;
   localparam int NODE_W     = $clog2(NODES + 1);
   localparam int LVL_W      = $clog2(LEVELS);
   localparam int KEY_DEPTH  = NODES;
   localparam int KEY_AW     = $clog2(KEY_DEPTH);
   localparam int LINK_DEPTH = LEVELS * (NODES + 1);
   localparam int LINK_AW    = $clog2(LINK_DEPTH);

   localparam logic [0:0] OP_INSERT  = 1'b0;
   localparam logic [0:0] OP_NEAREST = 1'b1;

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_DUPLICATE = 3'd1;
   localparam logic [2:0] ST_FOUND     = 3'd2;
   localparam logic [2:0] ST_EMPTY     = 3'd3;
   localparam logic [2:0] ST_FULL      = 3'd4;

   localparam logic [0:0] CSR_MAX_LEVEL = 1'b0;
   localparam logic [0:0] CSR_SEED      = 1'b1;

   localparam logic [NODE_W-1:0] NULL_IX = NODE_W'(NODES);

   typedef logic [NODE_W-1:0] node_type;

   // link address = level * (NODES+1) + node
   function automatic logic [LINK_AW-1:0] link_addr(input logic [LVL_W-1:0] lvl,
                                                   input node_type node);
      link_addr = LINK_AW'(lvl) * LINK_AW'(NODES + 1) + LINK_AW'(node);
   endfunction
endpackage
`default_nettype wire

### hw/rtl/skip_list_nearest_key_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// skip_list_nearest_key_top: sorted key set with nearest-key query
// Skip list of signed 32-bit keys in a node pool; insert and nearest search.
// ----------------------------------------------------------------------------
// Pulse start with req_op/req_key while busy is low. One result word comes
// back on rsp_status/rsp_nearest, marked by rsp_valid for one cycle; the
// receiver cannot stall it, so sample it when it shows. After reset the
// block sweeps the head links of all LEVELS levels to null, one level per
// cycle, with busy high. Each link followed in the search takes one
// link-memory read and one key-memory read (no key read when the link
// read is null; both are single-port RAMs). An insert adds the generator
// steps and, per spliced level, a pred-link read and two link writes; a
// nearest query adds a read of the left key.
module skip_list_nearest_key_top
   import sln_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output logic             busy,
   input  wire logic [0:0]  req_op,
   input  wire logic [31:0] req_key,
   output logic             rsp_valid,
   output logic [2:0]       rsp_status,
   output logic [31:0]      rsp_nearest,
   input  wire logic        csr_wr_en,
   input  wire logic [0:0]  csr_index,
   input  wire logic [30:0] csr_wr_data
);
   localparam logic [3:0] S_CLEAR  = 4'd0;
   localparam logic [3:0] S_IDLE   = 4'd1;
   localparam logic [3:0] S_LRD    = 4'd2;  // link read issued
   localparam logic [3:0] S_LWAIT  = 4'd3;  // link data arrives
   localparam logic [3:0] S_KWAIT  = 4'd4;  // key read issued
   localparam logic [3:0] S_DECIDE = 4'd5;  // compare key, advance or descend
   localparam logic [3:0] S_DRAW   = 4'd6;
   localparam logic [3:0] S_DWAIT  = 4'd7;
   localparam logic [3:0] S_SRD    = 4'd8;  // splice: read pred link
   localparam logic [3:0] S_SWAIT  = 4'd9;
   localparam logic [3:0] S_SW1    = 4'd10; // write new node link
   localparam logic [3:0] S_SW2    = 4'd11; // write pred link
   localparam logic [3:0] S_KEYWR  = 4'd12;
   localparam logic [3:0] S_LKEY   = 4'd13; // nearest: read left key
   localparam logic [3:0] S_LKWAIT = 4'd14;
   localparam logic [3:0] S_DONE   = 4'd15;

   logic [3:0]        state_ff, state_in;
   logic [3:0]        max_level_ff;
   logic [0:0]        op_ff;
   logic signed [31:0] key_ff;
   node_type          cur_ff, cur_in;
   node_type          nx_ff, nx_in;
   logic [LVL_W-1:0]  lvl_ff, lvl_in;
   logic [LVL_W-1:0]  top_ff, top_in;
   logic [LVL_W-1:0]  new_lvl_ff, new_lvl_in;
   logic [LVL_W-1:0]  sp_ff, sp_in;
   node_type          count_ff, count_in;
   node_type          preds_ff [LEVELS];
   logic signed [31:0] rkey_ff, rkey_in;
   logic              has_r_ff, has_r_in;
   logic [2:0]        st_ff, st_in;
   logic [31:0]       near_ff, near_in;

   logic              l_we, k_we;
   logic [LINK_AW-1:0] l_addr;
   logic [KEY_AW-1:0] k_addr;
   node_type          l_wd, l_rd;
   logic [31:0]       k_rd;
   logic              rng_step, rng_done;
   logic [30:0]       rng_val;
   logic [LVL_W-1:0]  eff_max;
   logic              set_pred;

   sln_ram #(.WIDTH(NODE_W), .DEPTH(LINK_DEPTH)) u_links (
      .clock(clock), .wr_en(l_we), .addr(l_addr), .wr_data(l_wd), .rd_data_ff(l_rd));
   sln_ram #(.WIDTH(32), .DEPTH(KEY_DEPTH)) u_keys (
      .clock(clock), .wr_en(k_we), .addr(k_addr), .wr_data(key_ff), .rd_data_ff(k_rd));
   sln_lehmer u_rng (
      .clock(clock), .reset(reset),
      .load(csr_wr_en && csr_index == CSR_SEED), .load_value(csr_wr_data),
      .step(rng_step), .done(rng_done), .value_ff(rng_val));

   assign eff_max = (max_level_ff == 4'd0) ? LVL_W'(1)
                  : (32'(max_level_ff) > LEVELS - 1) ? LVL_W'(LEVELS - 1)
                  : LVL_W'(max_level_ff);
   assign busy = (state_ff != S_IDLE);

   // 33-bit distances cannot overflow
   logic signed [32:0] dl, dr;
   assign dl = 33'(key_ff) - 33'($signed(k_rd));
   assign dr = 33'(signed'(rkey_ff)) - 33'(key_ff);

   always_comb begin
      state_in   = state_ff;
      cur_in     = cur_ff;
      nx_in      = nx_ff;
      lvl_in     = lvl_ff;
      top_in     = top_ff;
      new_lvl_in = new_lvl_ff;
      sp_in      = sp_ff;
      count_in   = count_ff;
      rkey_in    = rkey_ff;
      has_r_in   = has_r_ff;
      st_in      = st_ff;
      near_in    = near_ff;
      l_we       = 1'b0;
      l_addr     = link_addr(lvl_ff, cur_ff);
      l_wd       = NULL_IX;
      k_we       = 1'b0;
      k_addr     = nx_ff[KEY_AW-1:0];
      rng_step   = 1'b0;
      set_pred   = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            l_we   = 1'b1;
            l_addr = link_addr(lvl_ff, NULL_IX);
            lvl_in = lvl_ff + 1'b1;
            if (32'(lvl_ff) == LEVELS - 1) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (start) begin
               cur_in   = NULL_IX;
               lvl_in   = top_ff;
               state_in = S_LRD;
            end
         end
         S_LRD: begin
            state_in = S_LWAIT;
         end
         S_LWAIT: begin
            nx_in = l_rd;
            if (l_rd == NULL_IX) begin
               has_r_in = 1'b0;
               state_in = S_DECIDE;
            end else begin
               state_in = S_KWAIT;
            end
         end
         S_KWAIT: begin
            has_r_in = 1'b1;
            state_in = S_DECIDE;
         end
         S_DECIDE: begin
            if (has_r_ff && $signed(k_rd) < key_ff) begin
               cur_in   = nx_ff;
               state_in = S_LRD;
            end else begin
               set_pred = 1'b1;
               if (lvl_ff != '0) begin
                  lvl_in   = lvl_ff - 1'b1;
                  state_in = S_LRD;
               end else begin
                  rkey_in = k_rd;
                  if (op_ff == OP_INSERT) begin
                     if (has_r_ff && $signed(k_rd) == key_ff) begin
                        st_in = ST_DUPLICATE; near_in = '0; state_in = S_DONE;
                     end else if (32'(count_ff) >= NODES) begin
                        st_in = ST_FULL; near_in = '0; state_in = S_DONE;
                     end else begin
                        new_lvl_in = '0;
                        state_in   = S_DRAW;
                     end
                  end else if (cur_ff == NULL_IX && !has_r_ff) begin
                     st_in = ST_EMPTY; near_in = '0; state_in = S_DONE;
                  end else if (cur_ff == NULL_IX) begin
                     st_in = ST_FOUND; near_in = k_rd; state_in = S_DONE;
                  end else begin
                     state_in = S_LKEY;
                  end
               end
            end
         end
         S_LKEY: begin
            k_addr   = cur_ff[KEY_AW-1:0];
            state_in = S_LKWAIT;
         end
         S_LKWAIT: begin
            st_in = ST_FOUND;
            if (!has_r_ff) begin
               near_in = k_rd;
            end else begin
               near_in = ((dl < 0 ? -dl : dl) <= (dr < 0 ? -dr : dr)) ? k_rd : rkey_ff;
            end
            state_in = S_DONE;
         end
         S_DRAW: begin
            if (new_lvl_ff < eff_max) begin
               rng_step = 1'b1;
               state_in = S_DWAIT;
            end else begin
               sp_in = '0; state_in = S_KEYWR;
            end
         end
         S_DWAIT: begin
            if (rng_done) begin
               if (rng_val[0]) begin
                  new_lvl_in = new_lvl_ff + 1'b1;
                  state_in   = S_DRAW;
               end else begin
                  sp_in = '0; state_in = S_KEYWR;
               end
            end
         end
         S_KEYWR: begin
            k_we   = 1'b1;
            k_addr = count_ff[KEY_AW-1:0];
            if (new_lvl_ff > top_ff) begin
               top_in = new_lvl_ff;
            end
            state_in = S_SRD;
         end
         S_SRD: begin
            l_addr   = link_addr(sp_ff, (sp_ff > top_ff) ? NULL_IX : preds_ff[sp_ff]);
            state_in = S_SWAIT;
         end
         S_SWAIT: begin
            nx_in    = l_rd;
            state_in = S_SW1;
         end
         S_SW1: begin
            l_we     = 1'b1;
            l_addr   = link_addr(sp_ff, count_ff);
            l_wd     = nx_ff;
            state_in = S_SW2;
         end
         S_SW2: begin
            l_we   = 1'b1;
            l_addr = link_addr(sp_ff, (sp_ff > top_ff) ? NULL_IX : preds_ff[sp_ff]);
            l_wd   = count_ff;
            if (sp_ff == new_lvl_ff) begin
               if (new_lvl_ff > top_ff) begin
                  top_in = new_lvl_ff;
               end
               count_in = count_ff + 1'b1;
               st_in    = ST_INSERTED;
               near_in  = '0;
               state_in = S_DONE;
            end else begin
               sp_in    = sp_ff + 1'b1;
               state_in = S_SRD;
            end
         end
         S_DONE: begin
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         lvl_ff       <= '0;
         top_ff       <= '0;
         count_ff     <= '0;
         max_level_ff <= 4'd15;
      end else begin
         state_ff <= state_in;
         lvl_ff   <= lvl_in;
         top_ff   <= top_in;
         count_ff <= count_in;
         if (csr_wr_en && csr_index == CSR_MAX_LEVEL) begin
            max_level_ff <= csr_wr_data[3:0];
         end
      end
      cur_ff     <= cur_in;
      nx_ff      <= nx_in;
      new_lvl_ff <= new_lvl_in;
      sp_ff      <= sp_in;
      rkey_ff    <= rkey_in;
      has_r_ff   <= has_r_in;
      st_ff      <= st_in;
      near_ff    <= near_in;
      if (state_ff == S_IDLE && start) begin
         op_ff  <= req_op;
         key_ff <= req_key;
      end
      // hold the predecessor for every level the walk passes
      for (int i = 0; i < LEVELS; i++) begin
         if (state_ff == S_IDLE) begin
            preds_ff[i] <= NULL_IX;
         end else if (set_pred && LVL_W'(i) == lvl_ff) begin
            preds_ff[i] <= cur_ff;
         end
      end
   end

   assign rsp_valid   = (state_ff == S_DONE);
   assign rsp_status  = st_ff;
   assign rsp_nearest = near_ff;
endmodule
`default_nettype wire

### hw/rtl/sln_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sln_ram: generic single-port RAM
// One write or read per cycle, registered read data.
// ----------------------------------------------------------------------------
module sln_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data_ff <= mem[addr];
   end
endmodule
`default_nettype wire

### hw/rtl/sln_lehmer.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sln_lehmer: Lehmer generator step
// Multiply by 48271 into a product register, then fold modulo 2^31-1 into the value register.
// ----------------------------------------------------------------------------
module sln_lehmer
   import sln_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        load,
   input  wire logic [30:0] load_value,
   input  wire logic        step,      // start one step
   output logic             done,      // new value valid this cycle
   output logic [30:0]      value_ff
);
   logic [46:0] prod_ff;
   logic        busy_ff;
   logic        done_ff;
   logic [31:0] fold;
   logic [31:0] fold_red;

   // x mod (2^31-1) = hi + lo, then one conditional subtract
   assign fold     = {1'b0, prod_ff[30:0]} + {16'd0, prod_ff[46:31]};
   assign fold_red = (fold >= 32'h7FFF_FFFF) ? fold - 32'h7FFF_FFFF : fold;
   assign done     = done_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         value_ff <= 31'd1;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else begin
         busy_ff <= step;
         done_ff <= busy_ff;
         if (load) begin
            value_ff <= (load_value == 31'd0) ? 31'd1 : load_value;
         end else if (busy_ff) begin
            value_ff <= fold_red[30:0];
         end
      end
      prod_ff <= 47'(value_ff) * 47'd48271;
   end
endmodule
`default_nettype wire

### verif/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: testbench for the nearest-key skip list
// Drives inserts and nearest queries, predicts each answer from a sorted
// shadow of the key set and a copy of the level generator, and checks every
// result word in order.
// ----------------------------------------------------------------------------
module tb_top;
   import sln_pkg::*;

   localparam int QUIET_LIMIT = 20000;
   localparam int SETTLE      = 400;

   typedef struct packed {
      logic [0:0]  op;
      logic [31:0] key;
   } req_word_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [31:0] nearest;
   } rsp_word_type;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [0:0]  req_op;
   logic [31:0] req_key;
   logic        rsp_valid;
   logic [2:0]  rsp_status;
   logic [31:0] rsp_nearest;
   logic        csr_wr_en;
   logic [0:0]  csr_index;
   logic [30:0] csr_wr_data;

   skip_list_nearest_key_top DUT (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_op(req_op), .req_key(req_key),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status), .rsp_nearest(rsp_nearest),
      .csr_wr_en(csr_wr_en), .csr_index(csr_index), .csr_wr_data(csr_wr_data)
   );

   // Shadow of the block: the key set kept sorted, plus generator and limits.
   int signed   stored_keys[$];
   logic [3:0]  level_cap;
   longint      lehmer_state;

   req_word_type pending_words[$];
   rsp_word_type awaited_rsp[$];
   int          mismatch_count;
   int          quiet_cycles;
   int          send_idle_pct;
   bit          accept_seen;

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   task automatic report_mismatch(input string what);
      $display("MISMATCH @%0t: %s", $time, what);
      mismatch_count++;
   endtask

   // Mirror a register write in the shadow.
   task automatic shadow_csr(input logic [0:0] idx, input logic [30:0] val);
      if (idx == CSR_MAX_LEVEL) level_cap = val[3:0];
      else lehmer_state = (val == 0) ? 1 : longint'(val);
   endtask

   // Advance the generator once per level step; return the drawn level.
   function automatic int draw_node_level();
      int lvl;
      int cap;
      lvl = 0;
      cap = (level_cap < 1) ? 1 : ((level_cap > LEVELS - 1) ? LEVELS - 1 : level_cap);
      while (lvl < cap) begin
         lehmer_state = (lehmer_state * 48271) % 2147483647;
         if (lehmer_state[0] == 1'b0) break;
         lvl++;
      end
      return lvl;
   endfunction

   // Work out the answer for one word and update the shadow set.
   function automatic rsp_word_type predict_answer(input req_word_type w);
      rsp_word_type r;
      int signed   k;
      int          pos;
      longint      dl;
      longint      dr;
      k = w.key;
      r.nearest = '0;
      pos = 0;
      // pos = first index whose key is >= k
      while (pos < stored_keys.size() && stored_keys[pos] < k) pos++;
      if (w.op == OP_INSERT) begin
         if (pos < stored_keys.size() && stored_keys[pos] == k) begin
            r.status = ST_DUPLICATE;
         end else if (stored_keys.size() >= NODES) begin
            r.status = ST_FULL;
         end else begin
            void'(draw_node_level());
            stored_keys.insert(pos, k);
            r.status = ST_INSERTED;
         end
      end else if (stored_keys.size() == 0) begin
         r.status = ST_EMPTY;
      end else begin
         r.status = ST_FOUND;
         if (pos == 0) r.nearest = stored_keys[0];
         else if (pos == stored_keys.size()) r.nearest = stored_keys[pos-1];
         else begin
            dl = longint'(k) - longint'(stored_keys[pos-1]);
            dr = longint'(stored_keys[pos]) - longint'(k);
            r.nearest = (dl <= dr) ? stored_keys[pos-1] : stored_keys[pos];
         end
      end
      return r;
   endfunction

   // Driver: present one word at a time, change inputs on the falling edge.
   always @(negedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else if (accept_seen) begin
         // accepted at the last rising edge; pick the next word or drop start
         if (pending_words.size() > 1 && $urandom_range(99) >= send_idle_pct) begin
            void'(pending_words.pop_front());
            req_op  <= pending_words[0].op;
            req_key <= pending_words[0].key;
         end else begin
            void'(pending_words.pop_front());
            start <= 1'b0;
         end
      end else if (!start && pending_words.size() > 0
                   && $urandom_range(99) >= send_idle_pct) begin
         req_op  <= pending_words[0].op;
         req_key <= pending_words[0].key;
         start   <= 1'b1;
      end
   end

   // Monitor: predict on acceptance, check results, watch for a hang.
   always @(posedge clock) begin
      accept_seen <= start && !busy && !reset;
      if (!reset) begin
         if (start && !busy) awaited_rsp.push_back(predict_answer({req_op, req_key}));
         if (rsp_valid) begin
            if (awaited_rsp.size() == 0) begin
               report_mismatch("result word with nothing awaited");
            end else begin
               if (rsp_status !== awaited_rsp[0].status)
                  report_mismatch($sformatf("status %0d, predicted %0d",
                                  rsp_status, awaited_rsp[0].status));
               if (rsp_nearest !== awaited_rsp[0].nearest)
                  report_mismatch($sformatf("nearest %0d, predicted %0d",
                                  $signed(rsp_nearest), $signed(awaited_rsp[0].nearest)));
               void'(awaited_rsp.pop_front());
            end
         end
         if ((start && !busy) || rsp_valid) quiet_cycles <= 0;
         else quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Some tests failed");
            $finish;
         end
      end
   end

   task automatic push_word(input logic [0:0] op, input logic [31:0] key);
      pending_words.push_back('{op: op, key: key});
   endtask

   // Hold until every word is sent and answered, then let the block settle.
   task automatic drain();
      while (pending_words.size() > 0 || awaited_rsp.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   // Write a register while the block is idle.
   task automatic write_csr(input logic [0:0] idx, input logic [30:0] val);
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= idx;
      csr_wr_data <= val;
      @(negedge clock);
      csr_wr_en <= 1'b0;
      shadow_csr(idx, val);
   endtask

   // Random key: mostly near a small pool so duplicates and ties are common.
   function automatic logic [31:0] pick_key(input int span);
      case ($urandom_range(9))
         0: return $urandom();
         1: return 32'h8000_0000 + $urandom_range(3);
         2: return 32'h7FFF_FFFF - $urandom_range(3);
         default: return 32'($signed($urandom_range(2 * span)) - span);
      endcase
   endfunction

   task automatic random_phase(input int n, input int span);
      for (int i = 0; i < n; i++)
         push_word(($urandom_range(99) < 55) ? OP_INSERT : OP_NEAREST, pick_key(span));
      drain();
   endtask

   initial begin
      reset = 1'b1; start = 1'b0; req_op = OP_INSERT; req_key = '0;
      csr_wr_en = 1'b0; csr_index = CSR_MAX_LEVEL; csr_wr_data = '0;
      level_cap = 4'd15; lehmer_state = 1;
      mismatch_count = 0; quiet_cycles = 0; send_idle_pct = 23;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty query, extremes, ties, duplicates.
      push_word(OP_NEAREST, 32'd0);
      push_word(OP_INSERT, 32'h8000_0000);
      push_word(OP_NEAREST, 32'h7FFF_FFFF);
      push_word(OP_INSERT, 32'h7FFF_FFFF);
      push_word(OP_NEAREST, 32'h0000_0000);
      push_word(OP_NEAREST, 32'hFFFF_FFFF);
      push_word(OP_INSERT, 32'h8000_0000);
      push_word(OP_INSERT, 32'd10);
      push_word(OP_INSERT, 32'd20);
      push_word(OP_NEAREST, 32'd15);
      push_word(OP_NEAREST, 32'd16);
      push_word(OP_NEAREST, 32'd10);
      push_word(OP_NEAREST, 32'h8000_0000);
      push_word(OP_NEAREST, 32'h7FFF_FFFF);
      push_word(OP_INSERT, 32'hFFFF_FFFF);
      push_word(OP_INSERT, 32'h5555_5555);
      push_word(OP_INSERT, 32'hAAAA_AAAA);
      push_word(OP_NEAREST, 32'h4000_0000);
      drain();

      // Seed at the modulus: every later draw is zero.
      write_csr(CSR_SEED, 31'h7FFF_FFFF);
      write_csr(CSR_MAX_LEVEL, 4'd0);
      random_phase(100, 200);
      write_csr(CSR_SEED, 31'd0);
      write_csr(CSR_MAX_LEVEL, 4'd15);
      random_phase(150, 1000);

      send_idle_pct = 81;
      write_csr(CSR_SEED, 31'h2AAA_AAAA);
      write_csr(CSR_MAX_LEVEL, 4'd1);
      random_phase(150, 500);
      write_csr(CSR_SEED, 31'h5555_5555);
      write_csr(CSR_MAX_LEVEL, 4'd7);

      // Fill the pool to exercise the full status; no idling from here on.
      send_idle_pct = 0;
      for (int i = 0; i < NODES; i++) push_word(OP_INSERT, $urandom());
      drain();
      random_phase(100, 1 << 30);

      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end
endmodule
